// ----- rtl/core/wpf_pkg.sv -----
// shared types, constants and helpers of the waypoint path follower
`default_nettype none
package wpf_pkg;

    localparam int DIV_NW = 42;   // dividend width of the shared divider
    localparam int PER_W  = 19;   // divisor width, holds the loop period
    localparam int DIV_CW = 6;    // bit count width of the divider

    localparam int REG_NODE_COUNT = 0;
    localparam int REG_START      = 1;
    localparam int REG_NODE0      = 2;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [PER_W-1:0]  den;
        logic [DIV_CW-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [PER_W-1:0]  rem;
    } t_div_rsp;

    function automatic logic signed [23:0] node_x(input logic [63:0] v);
        return $signed(v[63:40]);
    endfunction

    function automatic logic signed [23:0] node_y(input logic [63:0] v);
        return $signed(v[39:16]);
    endfunction

    function automatic logic [15:0] node_dur(input logic [63:0] v);
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [42:0] hi;
        logic signed [42:0] lo;
        hi = 43'sd2147483647;
        lo = -43'sd2147483648;
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
        logic signed [41:0] hi;
        logic signed [41:0] lo;
        hi = 42'sd8388607;
        lo = -42'sd8388608;
        if (v > hi) return 24'sh7fffff;
        if (v < lo) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        hi = 18'sd32767;
        lo = -18'sd32768;
        if (v > hi) return 16'sh7fff;
        if (v < lo) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wpf_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module wpf_div
    import wpf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DIV_NW-1:0] r_num;
    logic [PER_W-1:0]  r_den;
    logic [PER_W-1:0]  r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic              num_bit;
    logic [PER_W:0]    trial;
    logic              ge;

    always_comb begin
        num_bit = r_num[r_cnt - 1'b1];
        trial   = {r_rem, num_bit};
        ge      = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? PER_W'(trial - {1'b0, r_den}) : trial[PER_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ----- rtl/core/waypoint_path_follower.sv -----
// waypoint path follower top level: registers, sequencer, multiplier, output stage
// paths: fewer than two waypoints, a zero period or a zero phase and step skip the divider; a zero
//   step runs only the phase wrap; otherwise the segment walk, then a target and a velocity division per axis
// transactions: one at a time, no new tick is taken until the result is loaded; the
//   bit-serial shared divider does the phase wrap and each target and velocity division
// reset: synchronous active low; registers, position, velocity and phase clear
`default_nettype none
module waypoint_path_follower
    import wpf_pkg::*;
#(
    parameter int NODES = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tick channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [15:0]                 i_delta,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [15:0]               o_pos_x,
    output logic signed [15:0]               o_pos_y,
    output logic signed [31:0]               o_vel_x,
    output logic signed [31:0]               o_vel_y,
    output logic                             o_period_fault,
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [$clog2((NODES+2)*8)-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);

    localparam int AW = $clog2((NODES + 2) * 8);
    localparam int IW = AW - 3;
    localparam int KI = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int KW = $clog2(NODES + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MODW = 11'b00000000010,
        S_WALK = 11'b00000000100,
        S_MULT = 11'b00000001000,
        S_TGO  = 11'b00000010000,
        S_TDIV = 11'b00000100000,
        S_VGO  = 11'b00001000000,
        S_VDIV = 11'b00010000000,
        S_IMUL = 11'b00100000000,
        S_IADD = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    // configuration registers
    logic [2:0]  r_node_count;
    logic [47:0] r_start;
    logic [63:0] r_node [NODES];

    // datapath state
    t_state             r_state, n_state;
    logic signed [23:0] r_pos_x, n_pos_x;
    logic signed [23:0] r_pos_y, n_pos_y;
    logic signed [31:0] r_vel_x, n_vel_x;
    logic signed [31:0] r_vel_y, n_vel_y;
    logic [23:0]        r_phase, n_phase;
    logic [15:0]        r_delta, n_delta;
    logic               r_fault, n_fault;
    logic [PER_W-1:0]   r_pt, n_pt;
    logic [KW-1:0]      r_k, n_k;
    logic signed [23:0] r_prev_x, n_prev_x;
    logic signed [23:0] r_prev_y, n_prev_y;
    logic [15:0]        r_d, n_d;
    logic               r_axis, n_axis;
    logic               r_neg, n_neg;
    logic signed [26:0] r_tgt, n_tgt;
    logic signed [49:0] r_prod;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_o_pos_x, r_o_pos_y;
    logic signed [31:0] r_o_vel_x, r_o_vel_y;
    logic               r_o_fault;

    logic               cfg_wr;
    logic [IW-1:0]      cfg_idx;
    logic [2:0]         n_use;
    logic [PER_W-1:0]   period;
    logic [24:0]        phase_sum;
    logic [63:0]        node_sel;
    logic signed [23:0] prev_sel;
    logic signed [23:0] next_sel;
    logic signed [23:0] pos_sel;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic [49:0]        prod_mag;
    logic [26:0]        diff_sh;
    logic signed [36:0] vnum;
    logic [36:0]        vnum_mag;
    logic [38:0]        inc_mag;
    logic signed [41:0] pos_sum;
    logic signed [26:0] q_tgt;
    logic signed [42:0] q_vel;
    logic [23:0]        rnd_mag_x, rnd_mag_y;
    logic [16:0]        rnd_x, rnd_y;
    logic               load_out;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[AW-1:3];

    // register reads
    always_comb begin
        prdata = '0;
        if (cfg_idx == IW'(REG_NODE_COUNT)) begin
            prdata = {61'd0, r_node_count};
        end else if (cfg_idx == IW'(REG_START)) begin
            prdata = {16'd0, r_start};
        end else begin
            for (int k = 0; k < NODES; k++) begin
                if (cfg_idx == IW'(REG_NODE0 + k)) begin
                    prdata = r_node[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_start      <= '0;
            for (int k = 0; k < NODES; k++) begin
                r_node[k] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx == IW'(REG_NODE_COUNT)) begin
                r_node_count <= pwdata[2:0];
            end else if (cfg_idx == IW'(REG_START)) begin
                r_start <= pwdata[47:0];
            end
            for (int k = 0; k < NODES; k++) begin
                if (cfg_idx == IW'(REG_NODE0 + k)) begin
                    r_node[k] <= pwdata;
                end
            end
        end
    end

    // waypoints in use, saturated, and loop period over segments 1 .. n-1
    always_comb begin
        n_use  = (r_node_count > 3'(NODES)) ? 3'(NODES) : r_node_count;
        period = '0;
        for (int k = 1; k < NODES; k++) begin
            if (k < int'(n_use)) begin
                period = period + PER_W'(node_dur(r_node[k]));
            end
        end
    end

    assign phase_sum = {1'b0, r_phase} + 25'(i_delta);
    assign node_sel  = r_node[r_k[KI-1:0]];
    assign prev_sel  = r_axis ? r_prev_y : r_prev_x;
    assign next_sel  = r_axis ? node_y(node_sel) : node_x(node_sel);
    assign pos_sel   = r_axis ? r_pos_y : r_pos_x;

    // shared multiplier: segment interpolation or integration step
    always_comb begin
        if (r_state == S_MULT) begin
            mul_a = 33'(next_sel) - 33'(prev_sel);
            mul_b = {1'b0, r_pt[15:0]};
        end else begin
            mul_a = r_axis ? 33'(r_vel_y) : 33'(r_vel_x);
            mul_b = {1'b0, r_delta};
        end
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MULT || r_state == S_IMUL) begin
            r_prod <= mul_p;
        end
    end

    // magnitudes and signed quotients around the divider
    always_comb begin
        prod_mag = r_prod[49] ? 50'(-r_prod) : 50'(r_prod);
        diff_sh  = 27'(r_tgt - 27'(pos_sel));
        vnum     = $signed({diff_sh[26:0], 10'd0});
        vnum_mag = vnum[36] ? 37'(-vnum) : 37'(vnum);
        inc_mag  = 39'((prod_mag[48:0] + 49'd512) >> 10);
        pos_sum  = 42'(pos_sel) + (r_prod[49] ? -$signed({3'b0, inc_mag})
                                              : $signed({3'b0, inc_mag}));
        q_tgt    = r_neg ? -$signed({2'b0, div_rsp.quo[24:0]})
                         : $signed({2'b0, div_rsp.quo[24:0]});
        q_vel    = r_neg ? -$signed({1'b0, div_rsp.quo})
                         : $signed({1'b0, div_rsp.quo});
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_vel_x     = r_vel_x;
        n_vel_y     = r_vel_y;
        n_phase     = r_phase;
        n_delta     = r_delta;
        n_fault     = r_fault;
        n_pt        = r_pt;
        n_k         = r_k;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_d         = r_d;
        n_axis      = r_axis;
        n_neg       = r_neg;
        n_tgt       = r_tgt;
        n_out_valid = r_out_valid && !i_ready;
        load_out    = 1'b0;
        div_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_delta = i_delta;
                    n_fault = 1'b0;
                    n_axis  = 1'b0;
                    if (n_use < 3'd2) begin
                        n_state = S_IMUL;
                    end else if (period == '0) begin
                        n_fault = 1'b1;
                        n_state = S_IMUL;
                    end else if (phase_sum == '0) begin
                        n_state = S_IMUL;
                    end else begin
                        // phase wrap: remainder of (s - 1) by the period
                        div_req.start = 1'b1;
                        div_req.num   = DIV_NW'(phase_sum - 25'd1);
                        div_req.den   = period;
                        div_req.nbits = DIV_CW'(25);
                        n_state       = S_MODW;
                    end
                end
            end
            S_MODW: begin
                if (div_rsp.done) begin
                    n_phase  = 24'(div_rsp.rem) + 24'd1;
                    n_pt     = div_rsp.rem + PER_W'(1);
                    n_k      = KW'(1);
                    n_prev_x = node_x(r_node[0]);
                    n_prev_y = node_y(r_node[0]);
                    n_state  = (r_delta == '0) ? S_IMUL : S_WALK;
                end
            end
            S_WALK: begin
                // one segment a cycle; zero-length segments fall through
                if (r_k >= KW'(n_use)) begin
                    n_state = S_IMUL;
                end else if (r_pt <= PER_W'(node_dur(node_sel))) begin
                    n_d     = node_dur(node_sel);
                    n_axis  = 1'b0;
                    n_state = S_MULT;
                end else begin
                    n_pt     = r_pt - PER_W'(node_dur(node_sel));
                    n_prev_x = node_x(node_sel);
                    n_prev_y = node_y(node_sel);
                    n_k      = r_k + KW'(1);
                end
            end
            S_MULT: begin
                n_state = S_TGO;
            end
            S_TGO: begin
                // rounded (next - prev) * pt / dur
                n_neg         = r_prod[49];
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(prod_mag[40:0]) + DIV_NW'(r_d >> 1);
                div_req.den   = PER_W'(r_d);
                div_req.nbits = DIV_CW'(42);
                n_state       = S_TDIV;
            end
            S_TDIV: begin
                if (div_rsp.done) begin
                    n_tgt   = 27'(prev_sel) + q_tgt;
                    n_state = S_VGO;
                end
            end
            S_VGO: begin
                // rounded (target - position) * 1024 / delta
                n_neg         = vnum[36];
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(vnum_mag) + DIV_NW'(r_delta >> 1);
                div_req.den   = PER_W'(r_delta);
                div_req.nbits = DIV_CW'(38);
                n_state       = S_VDIV;
            end
            S_VDIV: begin
                if (div_rsp.done) begin
                    if (r_axis) begin
                        n_vel_y = sat32(q_vel);
                        n_axis  = 1'b0;
                        n_state = S_IMUL;
                    end else begin
                        n_vel_x = sat32(q_vel);
                        n_axis  = 1'b1;
                        n_state = S_MULT;
                    end
                end
            end
            S_IMUL: begin
                n_state = S_IADD;
            end
            S_IADD: begin
                // position += rounded velocity * delta / 1024
                if (r_axis) begin
                    n_pos_y = sat24(pos_sum);
                    n_axis  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_pos_x = sat24(pos_sum);
                    n_axis  = 1'b1;
                    n_state = S_IMUL;
                end
            end
            S_OUT: begin
                // wait here only while the previous result is still pending
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start position write reloads position; user writes it only while idle, not enforced
        if (cfg_wr && cfg_idx == IW'(REG_START)) begin
            n_pos_x = $signed(pwdata[47:24]);
            n_pos_y = $signed(pwdata[23:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_phase     <= '0;
            r_axis      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_vel_x     <= n_vel_x;
            r_vel_y     <= n_vel_y;
            r_phase     <= n_phase;
            r_axis      <= n_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta  <= n_delta;
        r_fault  <= n_fault;
        r_pt     <= n_pt;
        r_k      <= n_k;
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_d      <= n_d;
        r_neg    <= n_neg;
        r_tgt    <= n_tgt;
    end

    // rounded position, halves away from zero
    always_comb begin
        rnd_mag_x = r_pos_x[23] ? 24'(-r_pos_x) : 24'(r_pos_x);
        rnd_mag_y = r_pos_y[23] ? 24'(-r_pos_y) : 24'(r_pos_y);
        rnd_x     = 17'((25'(rnd_mag_x) + 25'd128) >> 8);
        rnd_y     = 17'((25'(rnd_mag_y) + 25'd128) >> 8);
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_pos_x <= sat16(r_pos_x[23] ? -$signed({1'b0, rnd_x})
                                           : $signed({1'b0, rnd_x}));
            r_o_pos_y <= sat16(r_pos_y[23] ? -$signed({1'b0, rnd_y})
                                           : $signed({1'b0, rnd_y}));
            r_o_vel_x <= r_vel_x;
            r_o_vel_y <= r_vel_y;
            r_o_fault <= r_fault;
        end
    end

    wpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_pos_x        = r_o_pos_x;
    assign o_pos_y        = r_o_pos_y;
    assign o_vel_x        = r_o_vel_x;
    assign o_vel_y        = r_o_vel_y;
    assign o_period_fault = r_o_fault;

    // divider answers only arrive while the sequencer waits on one
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MODW || r_state == S_TDIV || r_state == S_VDIV))
        else $error("divider result outside a wait state");

    // an accepted tick makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accepting a tick");

    // a finished result never overwrites one still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_valid && !i_ready) |=> (r_state == S_OUT))
        else $error("result stage overwritten while pending");

endmodule
`default_nettype wire

// ----- sim/tb_waypoint_path_follower.sv -----
// self-checking testbench of the waypoint path follower: directed table, then random ticks
`timescale 1ns / 100ps
`default_nettype none
module tb_waypoint_path_follower;
    import wpf_pkg::*;

    localparam int NODES      = 6;
    localparam int SETTLE     = 250;     // a little above the worst-case latency
    localparam int STALL_MAX  = 20000;   // cycles with no transaction before giving up
    localparam int REG_COUNT  = REG_NODE0 + NODES;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // tick channel
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_delta = '0;
    // result channel
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_pos_x;
    logic signed [15:0] o_pos_y;
    logic signed [31:0] o_vel_x;
    logic signed [31:0] o_vel_y;
    logic               o_period_fault;
    // register port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    waypoint_path_follower #(.NODES(NODES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_delta(i_delta),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_vel_x(o_vel_x), .o_vel_y(o_vel_y),
        .o_period_fault(o_period_fault),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // one result transaction
    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               fault;
    } motion_t;

    // one row of the directed table: a register write or a tick
    typedef struct {
        bit          is_write;
        bit          typed;      // expected result given in the row
        int          reg_idx;
        logic [63:0] value;
        logic [15:0] delta;
        motion_t     motion;
    } step_row_t;

    motion_t   motion_q[$];
    step_row_t table_q[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // shadow of the block: registers and motion state
    logic [2:0]  sh_count;
    logic [63:0] sh_node[NODES];
    longint      sh_pos_x, sh_pos_y, sh_vel_x, sh_vel_y;
    longint      sh_phase;

    // round to nearest, halves away from zero
    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint wp_x(int k);
        logic signed [23:0] v;
        v = sh_node[k][63:40];
        return longint'(v);
    endfunction

    function automatic longint wp_y(int k);
        logic signed [23:0] v;
        v = sh_node[k][39:16];
        return longint'(v);
    endfunction

    function automatic void shadow_write(int idx, logic [63:0] value);
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        if (idx == REG_NODE_COUNT) begin
            sh_count = value[2:0];
        end else if (idx == REG_START) begin
            sx = value[47:24];
            sy = value[23:0];
            sh_pos_x = sx;
            sh_pos_y = sy;
        end else if (idx >= REG_NODE0 && idx < REG_COUNT) begin
            sh_node[idx - REG_NODE0] = value;
        end
    endfunction

    // advance the shadow by one tick and return the motion it reports
    function automatic motion_t track_tick(logic [15:0] delta);
        motion_t r;
        int      n;
        longint  period, s, pt, d, tx, ty, dl;
        bit      fault;
        dl = delta;
        fault = 1'b0;
        n = (sh_count > NODES) ? NODES : sh_count;
        if (n >= 2) begin
            period = 0;
            for (int k = 1; k < n; k++) period += sh_node[k][15:0];
            if (period == 0) begin
                fault = 1'b1;
            end else begin
                s = sh_phase + dl;
                if (s > 0) begin
                    sh_phase = (s - 1) % period + 1;
                    pt = sh_phase;
                    for (int k = 1; k < n && dl != 0; k++) begin
                        d = sh_node[k][15:0];
                        if (pt <= d) begin
                            tx = wp_x(k-1) + round_div((wp_x(k) - wp_x(k-1)) * pt, d);
                            ty = wp_y(k-1) + round_div((wp_y(k) - wp_y(k-1)) * pt, d);
                            sh_vel_x = clamp(round_div((tx - sh_pos_x) * 1024, dl), 32);
                            sh_vel_y = clamp(round_div((ty - sh_pos_y) * 1024, dl), 32);
                            break;
                        end
                        pt -= d;
                    end
                end
            end
        end
        sh_pos_x = clamp(sh_pos_x + round_div(sh_vel_x * dl, 1024), 24);
        sh_pos_y = clamp(sh_pos_y + round_div(sh_vel_y * dl, 1024), 24);
        r.pos_x = clamp(round_div(sh_pos_x, 256), 16);
        r.pos_y = clamp(round_div(sh_pos_y, 256), 16);
        r.vel_x = sh_vel_x;
        r.vel_y = sh_vel_y;
        r.fault = fault;
        return r;
    endfunction

    // receiver: random backpressure, result check and watchdog
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        motion_t e;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (motion_q.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end else begin
                e = motion_q.pop_front();
                if (o_pos_x !== e.pos_x) begin
                    $error("pos_x expected %0d got %0d", e.pos_x, o_pos_x); fail_count++;
                end
                if (o_pos_y !== e.pos_y) begin
                    $error("pos_y expected %0d got %0d", e.pos_y, o_pos_y); fail_count++;
                end
                if (o_vel_x !== e.vel_x) begin
                    $error("vel_x expected %0d got %0d", e.vel_x, o_vel_x); fail_count++;
                end
                if (o_vel_y !== e.vel_y) begin
                    $error("vel_y expected %0d got %0d", e.vel_y, o_vel_y); fail_count++;
                end
                if (o_period_fault !== e.fault) begin
                    $error("period_fault expected %0d got %0d", e.fault, o_period_fault);
                    fail_count++;
                end
            end
        end
    end

    // lower valid at the current edge, nothing else drives it here
    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    // wait until every expected result has come, then let the block settle
    task automatic drain();
        drop_valid();
        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(int idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_write(idx, value);
        @(posedge i_clk);
    endtask

    // send one tick transaction; typed rows replace the predicted result
    task automatic send_tick(logic [15:0] delta, bit typed, motion_t given);
        motion_t p;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_delta <= delta;
        do @(posedge i_clk); while (!o_ready);
        p = track_tick(delta);
        motion_q.push_back(typed ? given : p);
    endtask

    function automatic void add_write(int idx, logic [63:0] value);
        step_row_t r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.value = value;
        table_q.push_back(r);
    endfunction

    function automatic void add_tick(logic [15:0] delta);
        step_row_t r;
        r = '{default: '0};
        r.delta = delta;
        table_q.push_back(r);
    endfunction

    function automatic void add_typed(logic [15:0] delta, logic signed [15:0] px,
                                      logic signed [15:0] py, logic fault);
        step_row_t r;
        r = '{default: '0};
        r.typed = 1'b1;
        r.delta = delta;
        r.motion = '{px, py, 32'sd0, 32'sd0, fault};
        table_q.push_back(r);
    endfunction

    function automatic logic [23:0] rand_coord();
        if ($urandom_range(99) < 80) return 24'($signed($urandom_range(8192)) - 4096);
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] rand_dur();
        int c;
        c = $urandom_range(99);
        if (c < 10) return 16'd0;
        if (c < 15) return 16'($urandom);
        return 16'($urandom_range(1, 200));
    endfunction

    function automatic logic [15:0] rand_delta();
        int c;
        c = $urandom_range(99);
        if (c < 10) return 16'd0;
        if (c < 20) return 16'($urandom);
        if (c < 25) return 16'hffff;
        return 16'($urandom_range(1, 64));
    endfunction

    // new random setting: count and node registers, start on even phases; block idle
    task automatic random_setting(int ph);
        logic [63:0] v;
        logic [2:0]  cnt;
        cnt = ($urandom_range(99) < 80) ? 3'($urandom_range(2, NODES)) : 3'($urandom_range(7));
        v = {$urandom, $urandom};
        v[2:0] = cnt;
        reg_write(REG_NODE_COUNT, v);
        if (ph % 2 == 0) begin
            v = {$urandom, $urandom};
            if ($urandom_range(1) == 0) v[47:0] = {rand_coord(), rand_coord()};
            reg_write(REG_START, v);
        end
        for (int k = 0; k < NODES; k++) begin
            if ($urandom_range(99) < 10) v = {$urandom, $urandom};
            else v = {rand_coord(), rand_coord(), rand_dur()};
            reg_write(REG_NODE0 + k, v);
        end
    endtask

    initial begin
        step_row_t row;
        sh_count = '0;
        for (int k = 0; k < NODES; k++) sh_node[k] = '0;
        sh_pos_x = 0; sh_pos_y = 0; sh_vel_x = 0; sh_vel_y = 0; sh_phase = 0;

        // directed table
        add_typed(16'd0, 16'sd0, 16'sd0, 1'b0);           // idle after reset, zero step
        add_typed(16'hffff, 16'sd0, 16'sd0, 1'b0);        // no waypoints, longest step
        add_write(REG_NODE_COUNT, 64'd2);
        add_typed(16'd100, 16'sd0, 16'sd0, 1'b1);         // zero loop period holds motion
        add_write(REG_NODE0 + 1, {24'h7fffff, 24'h800000, 16'h0040});
        add_write(REG_NODE0, {24'h800000, 24'h7fffff, 16'hffff});
        add_typed(16'd0, 16'sd0, 16'sd0, 1'b0);           // phase and step both zero
        add_tick(16'd1);
        add_tick(16'hffff);
        add_tick(16'd0);                                  // zero step rewraps the phase
        add_write(REG_NODE_COUNT, 64'hffff_ffff_ffff_ffff); // count saturates to six
        add_tick(16'd64);
        add_write(REG_START, {16'hffff, 24'h7fffff, 24'h800000});
        add_tick(16'd0);                                  // position extremes, rounding saturates
        add_write(REG_NODE0 + 2, {24'h000100, 24'hffff00, 16'h0001});
        add_tick(16'd1);
        add_tick(16'd2);
        add_tick(16'd300);
        add_write(REG_NODE_COUNT, 64'd1);                 // single waypoint keeps integrating
        add_tick(16'd500);
        add_write(REG_NODE_COUNT, 64'd0);
        add_tick(16'd10);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_q[i]) begin
            row = table_q[i];
            if (row.is_write) begin
                drain();
                reg_write(row.reg_idx, row.value);
            end else begin
                send_tick(row.delta, row.typed, row.motion);
            end
        end

        // random part: twelve settings, idling pattern changes every four
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            if (ph < 4) begin
                send_idle_pct = 25; recv_idle_pct = 48;
            end else if (ph < 8) begin
                send_idle_pct = 48; recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_setting(ph);
            for (int t = 0; t < 36; t++) begin
                if (ph == 5 && t == 12) begin
                    // hold the sender until the block has emptied
                    drop_valid();
                    while (motion_q.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                send_tick(rand_delta(), 1'b0, '{default: '0});
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
